FILE: sv/emmp_pkg.sv
// emmp_pkg: shared constants, codes, queue command type and a helper for the
// embedding mean/max pooling block. Depends on nothing.
package emmp_pkg;

  localparam int MAX_DIM     = 64;
  localparam int MAX_TOKENS  = 512;
  localparam int ELEM_W      = 16;
  localparam int OUT_W       = 16;
  localparam int DIM_W       = 6;
  localparam int LEN_W       = 7;
  localparam int POS_W       = 7;
  localparam int MODE_W      = 2;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int TOK_W       = $clog2(MAX_TOKENS + 1);
  localparam int ACC_W       = ELEM_W + TOK_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_ELEM = 2'd0,
    ACT_EOT  = 2'd1,
    ACT_EMIT = 2'd2
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEAN = 2'd0,
    MODE_MAX  = 2'd1,
    MODE_ZERO = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_MODE     = 1'b0,
    CFG_VECTOR_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_FOLD = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD,
    BK_CALC,
    BK_DIV,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    cmd_e                     kind;
    logic [DIM_W-1:0]         addr;
    logic signed [ELEM_W-1:0] value;
    logic [TOK_W-1:0]         count;
    logic                     ovf;
  } cmd_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] vlen);
    logic [LEN_W-1:0] r;
    if (vlen == '0) begin
      r = LEN_W'(1);
    end else if (vlen > LEN_W'(MAX_DIM)) begin
      r = LEN_W'(MAX_DIM);
    end else begin
      r = vlen;
    end
    return r;
  endfunction

endpackage

FILE: sv/emmp_front.sv
// emmp_front: accepts input transfers, tracks element position, token count
// and overflow, and queues fold and emit commands. Depends on emmp_pkg.
module emmp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_valid_i,
  output logic                               s_ready_o,
  input  logic [emmp_pkg::ACT_W-1:0]         action_i,
  input  logic signed [emmp_pkg::ELEM_W-1:0] value_i,
  input  logic [emmp_pkg::LEN_W-1:0]         len_i,
  input  logic                               full_i,
  output logic                               push_o,
  output emmp_pkg::cmd_t                     cmd_o
);

  logic [emmp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [emmp_pkg::TOK_W-1:0] tok_q, tok_d, tok_cl;
  logic                       ovf_q, ovf_d, ovf_cl;
  logic                       accept;
  logic                       tok_full;

  assign s_ready_o = !full_i;
  assign accept    = s_valid_i && !full_i;
  assign tok_full  = (tok_q >= emmp_pkg::TOK_W'(emmp_pkg::MAX_TOKENS));

  always_comb begin
    tok_cl = tok_q;
    ovf_cl = ovf_q;
    if (tok_full) begin
      ovf_cl = 1'b1;
    end else begin
      tok_cl = tok_q + emmp_pkg::TOK_W'(1);
    end
  end

  always_comb begin
    pos_d  = pos_q;
    tok_d  = tok_q;
    ovf_d  = ovf_q;
    push_o = 1'b0;
    cmd_o  = '{kind: emmp_pkg::CMD_FOLD, addr: pos_q[emmp_pkg::DIM_W-1:0],
               value: value_i, count: tok_q, ovf: ovf_q};
    if (accept) begin
      case (action_i)
        emmp_pkg::ACT_ELEM: begin
          if (({1'b0, pos_q} < {1'b0, len_i}) && !tok_full) begin
            push_o = 1'b1;
          end
          if (pos_q != '1) begin
            pos_d = pos_q + emmp_pkg::POS_W'(1);
          end
        end
        emmp_pkg::ACT_EOT: begin
          tok_d = tok_cl;
          ovf_d = ovf_cl;
          pos_d = '0;
        end
        emmp_pkg::ACT_EMIT: begin
          push_o     = 1'b1;
          cmd_o.kind = emmp_pkg::CMD_EMIT;
          if (pos_q != '0) begin
            cmd_o.count = tok_cl;
            cmd_o.ovf   = ovf_cl;
          end
          pos_d = '0;
          tok_d = '0;
          ovf_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      tok_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      tok_q <= tok_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

FILE: sv/emmp_queue.sv
// emmp_queue: short command queue between the front and back parts.
// Depends on emmp_pkg for the command type and depth.
module emmp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  emmp_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output emmp_pkg::cmd_t head_o
);

  emmp_pkg::cmd_t              slot_q [emmp_pkg::QUEUE_DEPTH];
  logic [emmp_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [emmp_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (emmp_pkg::QPTR_W+1)'(emmp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + emmp_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + emmp_pkg::QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (emmp_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (emmp_pkg::QPTR_W+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/emmp_div.sv
// emmp_div: bit-serial restoring divider, signed sum by unsigned token count,
// quotient truncated toward zero. Depends on emmp_pkg for widths.
module emmp_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [emmp_pkg::ACC_W-1:0] dividend_i,
  input  logic [emmp_pkg::TOK_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic signed [emmp_pkg::ACC_W:0]   quot_o
);

  localparam int CNT_W = $clog2(emmp_pkg::ACC_W);

  logic                         busy_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         neg_q;
  logic [emmp_pkg::TOK_W-1:0]   dvs_q;
  logic [emmp_pkg::TOK_W:0]     rem_q;
  logic [emmp_pkg::ACC_W-1:0]   quo_q;
  logic [emmp_pkg::TOK_W:0]     rem_sh;
  logic [emmp_pkg::TOK_W+1:0]   trial;
  logic                         ge;
  logic [emmp_pkg::ACC_W-1:0]   mag;
  logic signed [emmp_pkg::ACC_W:0] q_ext;

  assign mag    = dividend_i[emmp_pkg::ACC_W-1] ? emmp_pkg::ACC_W'(-dividend_i)
                                                : emmp_pkg::ACC_W'(dividend_i);
  assign rem_sh = {rem_q[emmp_pkg::TOK_W-1:0], quo_q[emmp_pkg::ACC_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !trial[emmp_pkg::TOK_W+1];
  assign q_ext  = $signed({1'b0, quo_q});
  assign quot_o = neg_q ? -q_ext : q_ext;
  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[emmp_pkg::ACC_W-1];
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= ge ? trial[emmp_pkg::TOK_W:0] : rem_sh;
      quo_q <= {quo_q[emmp_pkg::ACC_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(emmp_pkg::ACC_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
    end
  end

endmodule

FILE: sv/emmp_back.sv
// emmp_back: executes queued commands on the accumulator RAM (fold by
// read-modify-write with forwarding, emit by walking the dimensions).
// Depends on emmp_pkg and emmp_div.
module emmp_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  emmp_pkg::cmd_t                     head_i,
  output logic                               pop_o,
  input  logic [emmp_pkg::MODE_W-1:0]        mode_i,
  input  logic [emmp_pkg::LEN_W-1:0]         len_i,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic signed [emmp_pkg::OUT_W-1:0]  pooled_o,
  output logic [emmp_pkg::DIM_W-1:0]         dim_o,
  output logic                               last_o,
  output logic                               ovf_o
);

  localparam int ACC_W = emmp_pkg::ACC_W;
  localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'(2 ** (emmp_pkg::OUT_W - 1) - 1);
  localparam logic signed [ACC_W:0] SAT_LO = (ACC_W+1)'(-(2 ** (emmp_pkg::OUT_W - 1)));

  function automatic logic signed [emmp_pkg::OUT_W-1:0] sat(input logic signed [ACC_W:0] x);
    logic signed [emmp_pkg::OUT_W-1:0] r;
    if (x > SAT_HI) begin
      r = SAT_HI[emmp_pkg::OUT_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[emmp_pkg::OUT_W-1:0];
    end else begin
      r = x[emmp_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  emmp_pkg::back_state_e state_q, state_d;

  logic signed [ACC_W-1:0]           mem [emmp_pkg::MAX_DIM];
  logic [emmp_pkg::MAX_DIM-1:0]      vld_q;
  logic signed [ACC_W-1:0]           rdata_q;
  logic [emmp_pkg::DIM_W-1:0]        rd_addr_q;
  logic                              rd_vld_q;
  logic [emmp_pkg::DIM_W-1:0]        raddr;

  logic                              fwd_v_q;
  logic [emmp_pkg::DIM_W-1:0]        fwd_addr_q;
  logic signed [ACC_W-1:0]           fwd_data_q;

  logic                              fold_v_q;
  logic [emmp_pkg::DIM_W-1:0]        fold_addr_q;
  logic signed [emmp_pkg::ELEM_W-1:0] fold_val_q;
  logic signed [ACC_W-1:0]           fold_ext;

  logic [emmp_pkg::DIM_W-1:0]        dim_q;
  logic [emmp_pkg::TOK_W-1:0]        count_q;
  logic                              eovf_q;
  logic signed [emmp_pkg::OUT_W-1:0] res_q, res_d;

  logic                              out_v_q;
  logic signed [emmp_pkg::OUT_W-1:0] out_val_q;
  logic [emmp_pkg::DIM_W-1:0]        out_dim_q;
  logic                              out_last_q;
  logic                              out_ovf_q;

  logic signed [ACC_W-1:0]           rd_eff;
  logic signed [ACC_W-1:0]           wdata;
  logic                              wr_en;
  logic                              is_mean, is_max;
  logic                              out_free, last_dim, load_out, clr;
  logic                              div_start, div_done;
  logic                              pop_fold, pop_emit;
  logic signed [ACC_W:0]             div_quot;

  assign is_mean  = (mode_i == emmp_pkg::MODE_MEAN);
  assign is_max   = (mode_i == emmp_pkg::MODE_MAX);
  assign out_free = !out_v_q || m_ready_i;
  assign last_dim = ({1'b0, dim_q} == (len_i - emmp_pkg::LEN_W'(1)));

  assign rd_eff   = (fwd_v_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q
                  : (rd_vld_q ? rdata_q : '0);
  assign fold_ext = $signed({{(ACC_W - emmp_pkg::ELEM_W){fold_val_q[emmp_pkg::ELEM_W-1]}},
                             fold_val_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      emmp_pkg::BK_IDLE: begin
        if (!empty_i && (head_i.kind == emmp_pkg::CMD_EMIT)) begin
          state_d = emmp_pkg::BK_RD;
        end
      end
      emmp_pkg::BK_RD:   state_d = emmp_pkg::BK_CALC;
      emmp_pkg::BK_CALC: begin
        state_d = (is_mean && (count_q != '0)) ? emmp_pkg::BK_DIV : emmp_pkg::BK_OUT;
      end
      emmp_pkg::BK_DIV: begin
        if (div_done) begin
          state_d = emmp_pkg::BK_OUT;
        end
      end
      emmp_pkg::BK_OUT: begin
        if (out_free) begin
          state_d = last_dim ? emmp_pkg::BK_IDLE : emmp_pkg::BK_RD;
        end
      end
      default: state_d = emmp_pkg::BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o     = (state_q == emmp_pkg::BK_IDLE) && !empty_i;
    pop_fold  = pop_o && (head_i.kind == emmp_pkg::CMD_FOLD);
    pop_emit  = pop_o && (head_i.kind == emmp_pkg::CMD_EMIT);
    raddr     = (state_q == emmp_pkg::BK_IDLE) ? head_i.addr : dim_q;
    div_start = (state_q == emmp_pkg::BK_CALC) && is_mean && (count_q != '0);
    load_out  = (state_q == emmp_pkg::BK_OUT) && out_free;
    clr       = load_out && last_dim;
  end

  always_comb begin
    res_d = res_q;
    if (state_q == emmp_pkg::BK_CALC) begin
      res_d = is_max ? sat($signed({rd_eff[ACC_W-1], rd_eff})) : '0;
    end else if ((state_q == emmp_pkg::BK_DIV) && div_done) begin
      res_d = sat(div_quot);
    end
  end

  always_comb begin
    wr_en = fold_v_q && (is_mean || is_max);
    wdata = rd_eff;
    if (is_mean) begin
      wdata = rd_eff + fold_ext;
    end else if (fold_ext > rd_eff) begin
      wdata = fold_ext;
    end
  end

  emmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_eff),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fold_addr_q] <= wdata;
    end
    rdata_q   <= mem[raddr];
    rd_addr_q <= raddr;
    rd_vld_q  <= vld_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    fold_addr_q <= head_i.addr;
    fold_val_q  <= head_i.value;
    res_q       <= res_d;
    if (wr_en) begin
      fwd_addr_q <= fold_addr_q;
      fwd_data_q <= wdata;
    end
    if (pop_emit) begin
      count_q <= head_i.count;
      eovf_q  <= head_i.ovf;
    end
    if (load_out) begin
      out_val_q  <= res_q;
      out_dim_q  <= dim_q;
      out_last_q <= last_dim;
      out_ovf_q  <= eovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= emmp_pkg::BK_IDLE;
      vld_q    <= '0;
      fwd_v_q  <= 1'b0;
      fold_v_q <= 1'b0;
      dim_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fold_v_q <= pop_fold;
      if (clr) begin
        vld_q   <= '0;
        fwd_v_q <= 1'b0;
      end else if (wr_en) begin
        vld_q[fold_addr_q] <= 1'b1;
        fwd_v_q            <= 1'b1;
      end
      if (pop_emit) begin
        dim_q <= '0;
      end else if (load_out && !last_dim) begin
        dim_q <= dim_q + emmp_pkg::DIM_W'(1);
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = out_v_q;
  assign pooled_o  = out_val_q;
  assign dim_o     = out_dim_q;
  assign last_o    = out_last_q;
  assign ovf_o     = out_ovf_q;

endmodule

FILE: sv/embedding_mean_max_pooling.sv
// embedding_mean_max_pooling: top level with configuration registers, front,
// command queue and back. Depends on emmp_pkg, emmp_front, emmp_queue, emmp_back.
// Throughput: one input transfer per cycle while the queue has room; folds run one
// per cycle through the accumulator RAM with write forwarding while the back part
// is idle. Emit: each dimension walks read, calc, divide (mean mode, nonzero count)
// and output states. Async reset clears control state and valid bits, not the RAM.
module embedding_mean_max_pooling (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [emmp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [emmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [15:0]                          s_axis_tdata,  // element_value
  input  logic [emmp_pkg::ACT_W-1:0]           s_axis_tuser,  // action
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // pooled_value, dim_index
  output logic                                 m_axis_tlast,  // last_of_vector
  output logic [0:0]                           m_axis_tuser   // token_overflow
);

  logic [emmp_pkg::MODE_W-1:0]      mode_q;
  logic [emmp_pkg::LEN_W-1:0]       vlen_q;
  logic [emmp_pkg::LEN_W-1:0]       len;
  logic                             q_push, q_pop, q_full, q_empty;
  emmp_pkg::cmd_t                   q_in, q_head;
  logic signed [emmp_pkg::OUT_W-1:0] pooled;
  logic [emmp_pkg::DIM_W-1:0]       dim;
  logic                             ovf;

  assign len = emmp_pkg::eff_len(vlen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= emmp_pkg::MODE_MEAN;
      vlen_q <= emmp_pkg::LEN_W'(emmp_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        emmp_pkg::CFG_POOL_MODE:     mode_q <= cfg_data_i[emmp_pkg::MODE_W-1:0];
        emmp_pkg::CFG_VECTOR_LENGTH: vlen_q <= cfg_data_i[emmp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  emmp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .action_i  (s_axis_tuser),
    .value_i   ($signed(s_axis_tdata)),
    .len_i     (len),
    .full_i    (q_full),
    .push_o    (q_push),
    .cmd_o     (q_in)
  );

  emmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  emmp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (q_empty),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .mode_i    (mode_q),
    .len_i     (len),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .pooled_o  (pooled),
    .dim_o     (dim),
    .last_o    (m_axis_tlast),
    .ovf_o     (ovf)
  );

  assign m_axis_tdata = {2'b00, dim, pooled};
  assign m_axis_tuser = ovf;

  a_no_push_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full
  ) else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty
  ) else $error("command popped from an empty queue");

endmodule

FILE: sim/tb_embedding_mean_max_pooling.sv
// tb_embedding_mean_max_pooling: self-checking bench for the embedding mean/max pooling
// block, with directed and random token sets, random stalls and an in-order result predictor.
// Depends on emmp_pkg and embedding_mean_max_pooling.
module tb_embedding_mean_max_pooling;
  timeunit 1ns;
  timeprecision 1ps;

  import emmp_pkg::*;

  localparam logic [ACT_W-1:0]  ACT_NONE  = 2'd3;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 2500;
  localparam int CYCLE_LIMIT   = 20000000;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic [DIM_W-1:0] dim;
    logic             last;
    logic             ovf;
  } pooled_t;

  class pooling_tracker;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  vlen;
    longint            acc [MAX_DIM];
    int unsigned       pos;
    int unsigned       tokens;
    bit                ovf_seen;
    pooled_t           pooled_q[$];
    int unsigned       failures;

    function void clear_set();
      foreach (acc[i]) acc[i] = 0;
      pos      = 0;
      tokens   = 0;
      ovf_seen = 1'b0;
    endfunction

    function void clear();
      mode = MODE_MEAN;
      vlen = LEN_W'(MAX_DIM);
      clear_set();
      pooled_q.delete();
      failures = 0;
    endfunction

    function int unsigned dims();
      if (vlen == 0) return 1;
      if (vlen > MAX_DIM) return MAX_DIM;
      return vlen;
    endfunction

    function int unsigned pending();
      return pooled_q.size();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_POOL_MODE) begin
        mode = data[MODE_W-1:0];
      end else begin
        vlen = data[LEN_W-1:0];
      end
    endfunction

    function void close_token();
      if (tokens >= MAX_TOKENS) begin
        ovf_seen = 1'b1;
      end else begin
        tokens++;
      end
      pos = 0;
    endfunction

    function void take_item(logic [ACT_W-1:0] act, logic [ELEM_W-1:0] raw);
      longint      v;
      longint      r;
      int unsigned n;
      pooled_t     p;
      v = longint'($signed(raw));
      case (act)
        ACT_ELEM: begin
          if (pos < dims() && tokens < MAX_TOKENS) begin
            if (mode == MODE_MEAN) begin
              acc[pos] += v;
            end else if (mode == MODE_MAX && v > acc[pos]) begin
              acc[pos] = v;
            end
          end
          if (pos < 127) pos++;
        end
        ACT_EOT: begin
          close_token();
        end
        ACT_EMIT: begin
          n = dims();
          if (pos != 0) close_token();
          for (int i = 0; i < n; i++) begin
            r = 0;
            if (mode == MODE_MEAN) begin
              if (tokens != 0) r = acc[i] / longint'(tokens);
            end else if (mode == MODE_MAX) begin
              r = acc[i];
            end
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            p.value = r[OUT_W-1:0];
            p.dim   = i[DIM_W-1:0];
            p.last  = (i + 1 == n);
            p.ovf   = ovf_seen;
            pooled_q.insert(pooled_q.size(), p);
          end
          clear_set();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_pooled(logic [OUT_W-1:0] value, logic [DIM_W-1:0] dim,
                               logic last, logic ovf);
      pooled_t w;
      if (pooled_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: value %h dim %0d last %b ovf %b", value, dim, last, ovf);
      end else begin
        w = pooled_q.pop_front();
        if (w.value !== value || w.dim !== dim || w.last !== last || w.ovf !== ovf) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected value %h dim %0d last %b ovf %b, got %h %0d %b %b",
                     w.value, w.dim, w.last, w.ovf, value, dim, last, ovf);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // element_value
  logic [ACT_W-1:0]      s_axis_tuser  = '0;  // action
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // pooled_value, dim_index
  logic                  m_axis_tlast;        // last_of_vector
  logic [0:0]            m_axis_tuser;        // token_overflow

  pooling_tracker sb;
  bit             steady   = 1'b0;
  bit             hold_req = 1'b0;
  int unsigned    items_sent = 0;
  int unsigned    cycles     = 0;

  embedding_mean_max_pooling uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[embedding_mean_max_pooling] ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 16);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_pooled(m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tlast, m_axis_tuser[0]);
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [15:0] raw);
    while (!steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(act, raw);
    if (act != ACT_NONE) items_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(19))
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd64;
      3:       return 7'($urandom_range(65, 126));
      4, 5:    return 7'($urandom_range(9, 63));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return MODE_ZERO;
    if (r == 1) return MODE_NONE;
    if (r <= 5) return MODE_MEAN;
    return MODE_MAX;
  endfunction

  task automatic send_set(input bit leave_open);
    int unsigned ntok;
    int unsigned n;
    int unsigned r;
    ntok = $urandom_range(0, 5);
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(49);
      if (r == 0) begin
        n = 130;
      end else if (r < 20) begin
        n = $urandom_range(0, sb.dims() + 3);
      end else begin
        n = sb.dims();
      end
      for (int e = 0; e < n; e++) begin
        if ($urandom_range(19) == 0) send_item(ACT_NONE, 16'($urandom));
        send_item(ACT_ELEM, pick_value());
      end
      if (t != ntok - 1 || $urandom_range(3) != 0) send_item(ACT_EOT, 16'($urandom));
    end
    if (!leave_open) send_item(ACT_EMIT, 16'($urandom));
  endtask

  initial begin
    int unsigned phase;
    sb = new;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, extra element, short token, empty token, idle action, empty set
    write_reg(CFG_POOL_MODE, 7'(MODE_MEAN));
    write_reg(CFG_VECTOR_LENGTH, 7'd4);
    send_item(ACT_ELEM, 16'h7FFF);
    send_item(ACT_ELEM, 16'h8000);
    send_item(ACT_ELEM, 16'h0001);
    send_item(ACT_ELEM, 16'hFFFF);
    send_item(ACT_ELEM, 16'h1234);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_ELEM, 16'h7FFF);
    send_item(ACT_ELEM, 16'h8000);
    send_item(ACT_EOT, 16'hFFFF);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_NONE, 16'hFFFF);
    send_item(ACT_EMIT, 16'h0000);
    send_item(ACT_EMIT, 16'hFFFF);

    // max mode, length zero, open token at emit
    settle();
    write_reg(CFG_POOL_MODE, 7'(MODE_MAX));
    write_reg(CFG_VECTOR_LENGTH, 7'd0);
    send_item(ACT_ELEM, 16'h8000);
    send_item(ACT_ELEM, 16'h0005);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_ELEM, 16'h7FFF);
    send_item(ACT_EMIT, 16'h0000);

    // zero modes, oversized length
    settle();
    write_reg(CFG_POOL_MODE, 7'(MODE_ZERO));
    write_reg(CFG_VECTOR_LENGTH, 7'd127);
    send_item(ACT_ELEM, 16'h1111);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_EMIT, 16'h0000);
    settle();
    write_reg(CFG_POOL_MODE, 7'h7F);
    write_reg(CFG_VECTOR_LENGTH, 7'd2);
    send_item(ACT_ELEM, 16'h0100);
    send_item(ACT_EMIT, 16'h0000);

    // mode change within a set
    settle();
    write_reg(CFG_POOL_MODE, 7'(MODE_MEAN));
    send_item(ACT_ELEM, 16'h0100);
    send_item(ACT_ELEM, 16'hFE00);
    send_item(ACT_EOT, 16'h0000);
    settle();
    write_reg(CFG_POOL_MODE, 7'(MODE_MAX));
    send_item(ACT_ELEM, 16'h0050);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_EMIT, 16'h0000);

    // token limit
    settle();
    write_reg(CFG_POOL_MODE, 7'(MODE_MEAN));
    write_reg(CFG_VECTOR_LENGTH, 7'd1);
    send_item(ACT_ELEM, 16'h0400);
    repeat (MAX_TOKENS + 3) send_item(ACT_EOT, 16'($urandom));
    send_item(ACT_ELEM, 16'h7000);
    send_item(ACT_EOT, 16'h0000);
    send_item(ACT_EMIT, 16'h0000);

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = (phase == 1);
      settle();
      write_reg(CFG_POOL_MODE, {5'($urandom), pick_mode()});
      write_reg(CFG_VECTOR_LENGTH, pick_length());
      if (phase == 2) begin
        // receiver held off while an emit and a full token back up the queue
        hold_req = 1'b1;
        write_reg(CFG_VECTOR_LENGTH, 7'd8);
        send_item(ACT_EMIT, 16'($urandom));
        repeat (8) send_item(ACT_ELEM, pick_value());
      end
      for (int s = $urandom_range(1, 3); s > 0; s--)
        send_set(phase != 2 && $urandom_range(9) == 0);
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (64) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[embedding_mean_max_pooling] OK");
    end else begin
      $display("[embedding_mean_max_pooling] ERROR");
    end
    $finish;
  end

endmodule
